/* rtl/core/stbi_pkg.sv */
// Shared types and constants for the sorted table with binary insertion.
// No dependencies; every other file of the block imports this package.
package stbi_pkg;

  localparam int TABLE_DEPTH = 16;

  // Table addressing, derived from the depth
  localparam int TAB_IDX_W = $clog2(TABLE_DEPTH);
  localparam int TAB_CNT_W = $clog2(TABLE_DEPTH + 1);

  // Field widths of the beats
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int POS_W    = 4;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Control broadcast along the row of cells
  typedef struct packed {
    logic                       wr_en;
    logic                       shift;
    logic [TAB_IDX_W-1:0]       pos;
    logic signed [VALUE_W-1:0]  data;
  } cell_ctl_t;

  // One result beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    logic [POS_W-1:0]          position;
    logic [FILL_W-1:0]         fill;
    status_t                   status;
  } result_t;

endpackage

/* rtl/core/stbi_cell.sv */
// One table entry of the cell row: written in place or taken from its left neighbour.
// Depends on stbi_pkg.
module stbi_cell import stbi_pkg::*; (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic [TAB_IDX_W-1:0]      my_index,
  input  logic signed [VALUE_W-1:0] left_q,
  output logic signed [VALUE_W-1:0] q
);

  // Entry contents are undefined until written: no reset
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.pos == my_index)) begin
      q <= ctl.data;
    end else if (ctl.shift && (my_index > ctl.pos)) begin
      q <= left_q;
    end
  end

endmodule

/* rtl/core/stbi_ctrl.sv */
// Command sequencer: fill count, iterative upper-bound search, cell row control.
// Depends on stbi_pkg.
module stbi_ctrl import stbi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                command,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [INDEX_W-1:0]        index,
  output logic [TAB_IDX_W-1:0]      rd_addr,
  input  logic signed [VALUE_W-1:0] rd_data,
  output cell_ctl_t                 ctl,
  output logic                      res_valid,
  output result_t                   res,
  input  logic                      res_taken
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic [TAB_CNT_W-1:0]      fill_cnt, fill_cnt_next;
  logic [TAB_CNT_W-1:0]      lo, lo_next, hi, hi_next, mid;
  cmd_t                      cmd_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [INDEX_W-1:0]        idx_q;
  result_t                   res_next;
  logic                      full, in_range, key_ge, in_fire;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state == S_EMIT);
  assign full      = (fill_cnt == TAB_CNT_W'(TABLE_DEPTH));
  assign in_range  = (int'(idx_q) < int'(fill_cnt)) && (int'(idx_q) < TABLE_DEPTH);
  assign mid       = lo + ((hi - lo) >> 1);
  assign key_ge    = (val_q >= rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill_cnt <= '0;
    end else begin
      state    <= state_next;
      fill_cnt <= fill_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= cmd_t'(command);
      val_q <= value;
      idx_q <= index;
    end
    lo  <= lo_next;
    hi  <= hi_next;
    res <= res_next;
  end

  always_comb begin
    state_next    = state;
    fill_cnt_next = fill_cnt;
    lo_next       = lo;
    hi_next       = hi;
    res_next      = res;
    rd_addr       = TAB_IDX_W'(idx_q);
    ctl.wr_en     = 1'b0;
    ctl.shift     = 1'b0;
    ctl.pos       = TAB_IDX_W'(fill_cnt);
    ctl.data      = val_q;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_EMIT;
        case (cmd_q)
          CMD_LOAD: begin
            if (full) begin
              res_next = '{val_q, '0, FILL_W'(fill_cnt), ST_FULL};
            end else begin
              ctl.wr_en     = 1'b1;
              fill_cnt_next = fill_cnt + 1'b1;
              res_next      = '{val_q, POS_W'(fill_cnt), FILL_W'(fill_cnt_next), ST_OK};
            end
          end
          CMD_INSERT: begin
            if (full) begin
              res_next = '{val_q, '0, FILL_W'(fill_cnt), ST_FULL};
            end else begin
              lo_next    = '0;
              hi_next    = fill_cnt;
              state_next = S_SEARCH;
            end
          end
          CMD_READ: begin
            if (in_range) begin
              res_next = '{rd_data, POS_W'(idx_q), FILL_W'(fill_cnt), ST_OK};
            end else begin
              res_next = '{'0, POS_W'(idx_q), FILL_W'(fill_cnt), ST_RANGE};
            end
          end
          default: begin
            fill_cnt_next = '0;
            res_next      = '{'0, '0, '0, ST_OK};
          end
        endcase
      end
      S_SEARCH: begin
        if (lo < hi) begin
          // One halving step per cycle
          rd_addr = TAB_IDX_W'(mid);
          if (key_ge) begin
            lo_next = mid + 1'b1;
          end else begin
            hi_next = mid;
          end
        end else begin
          // Open a gap at the bound and drop the key into it
          ctl.wr_en     = 1'b1;
          ctl.shift     = 1'b1;
          ctl.pos       = TAB_IDX_W'(lo);
          fill_cnt_next = fill_cnt + 1'b1;
          res_next      = '{val_q, POS_W'(lo), FILL_W'(fill_cnt_next), ST_OK};
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/sorted_table_binary_insert_top.sv */
// Top level of the sorted table with binary insertion: cell row, sequencer, output register.
// Depends on stbi_pkg, stbi_cell and stbi_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: command, value, index.
//   Output channel (out_valid/out_ready) returns exactly one result beat per command:
//   data, position, fill (entries held afterwards) and status.
//   Load appends, insert places the value after all entries not greater than it,
//   read returns entry index, clear empties the table. A full table answers load and
//   insert with status full; a read at or beyond the fill gives status range.
// Search: insert runs a binary search of at most $clog2(TABLE_DEPTH) steps
//   (4 at a depth of 16). The search is set by the shared compare against the entry
//   picked from the cell row, one halving step per cycle.
// Flow: one command at a time; the next beat is taken the cycle after a result
//   moves into the output register.
// Reset: synchronous; empties the table (fill zero) and drops any pending result.
// Stall: a result waits in the output register while out_ready is low; the sequencer
//   may accept and work the next command, then holds its result until the slot frees.
module sorted_table_binary_insert_top import stbi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic [INDEX_W-1:0]         index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  data,
  output logic [POS_W-1:0]           position,
  output logic [FILL_W-1:0]          fill,
  output logic [STATUS_W-1:0]        status
);

  logic signed [VALUE_W-1:0] cell_q [TABLE_DEPTH];
  logic [TAB_IDX_W-1:0]      rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  cell_ctl_t                 ctl;
  logic                      res_valid, res_taken;
  result_t                   res;

  // Row of entry cells; each above the write position takes its left neighbour's entry on a shift
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left;
    if (g == 0) begin : g_first
      assign left = cell_q[0];
    end else begin : g_rest
      assign left = cell_q[g-1];
    end
    stbi_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .my_index (TAB_IDX_W'(g)),
      .left_q   (left),
      .q        (cell_q[g])
    );
  end

  // Single read tap into the row: search midpoint or read index
  assign rd_data = cell_q[rd_addr];

  stbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .index     (index),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .ctl       (ctl),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // Output register: advance a finished result when the slot is empty or draining
  assign res_taken = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      data     <= res.data;
      position <= res.position;
      fill     <= res.fill;
      status   <= res.status;
    end
  end

endmodule

/* test/stbi_table_monitor.sv */
`timescale 1ns / 1ps
// Checker for sorted_table_binary_insert_top. It watches both channels, keeps its own copy
// of the table and compares every result beat field by field. Depends on stbi_pkg.
module stbi_table_monitor import stbi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                command,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [INDEX_W-1:0]        index,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [VALUE_W-1:0] data,
  input  logic [POS_W-1:0]          position,
  input  logic [FILL_W-1:0]         fill,
  input  logic [STATUS_W-1:0]       status,
  output int                        commands_taken,
  output int                        results_taken,
  output int                        mismatches
);

  logic signed [VALUE_W-1:0] slots [TABLE_DEPTH];
  int                        held = 0;
  int                        errs = 0;
  result_t                   results_due [$];

  assign mismatches = errs;

  task automatic report_mismatch(input string what, input logic signed [VALUE_W:0] got,
                                 input logic signed [VALUE_W:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errs++;
  endtask

  // Apply one command to the shadow table and return the beat it should produce.
  function automatic result_t place_command(input cmd_t op,
                                            input logic signed [VALUE_W-1:0] v,
                                            input logic [INDEX_W-1:0] idx);
    result_t r;
    int      lo;
    int      hi;
    int      mid;
    int      k;
    r.data     = '0;
    r.position = '0;
    r.status   = ST_OK;
    case (op)
      CMD_LOAD: begin
        r.data = v;
        if (held >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[held] = v;
          r.position  = held[POS_W-1:0];
          held++;
        end
      end
      CMD_INSERT: begin
        r.data = v;
        if (held >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // upper bound: equal keys land after the entries that match them
          lo = 0;
          hi = held;
          while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (v >= slots[mid]) lo = mid + 1;
            else hi = mid;
          end
          for (k = held; k > lo; k--) slots[k] = slots[k-1];
          slots[lo]  = v;
          r.position = lo[POS_W-1:0];
          held++;
        end
      end
      CMD_READ: begin
        r.position = idx;
        if (int'(idx) >= held) r.status = ST_RANGE;
        else r.data = slots[idx];
      end
      CMD_CLEAR: begin
        held = 0;
      end
    endcase
    r.fill = held[FILL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      held = 0;
      results_due.delete();
      commands_taken <= 0;
      results_taken  <= 0;
    end else begin
      // retire first: a beat leaving now can never belong to a command taken now
      if (out_valid && out_ready) begin
        results_taken <= results_taken + 1;
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, data", data, '0);
        end else begin
          want = results_due.pop_front();
          if (data !== want.data) report_mismatch("data", data, want.data);
          if (position !== want.position) report_mismatch("position", position, want.position);
          if (fill !== want.fill) report_mismatch("fill", fill, want.fill);
          if (status !== want.status) report_mismatch("status", status, want.status);
        end
      end
      if (in_valid && in_ready) begin
        commands_taken <= commands_taken + 1;
        results_due.push_back(place_command(cmd_t'(command), value, index));
      end
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench top for sorted_table_binary_insert_top: clock, reset, command beats and output
// back-pressure, with the verdict. Depends on stbi_pkg and the checker stbi_table_monitor.
module tb;
  import stbi_pkg::*;

  localparam int ITEMS       = 1050;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;
  // leave a comfortable margin after the last beat
  localparam int TAIL_CYCLES = 32;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [1:0]                command   = CMD_CLEAR;
  logic signed [VALUE_W-1:0] value     = '0;
  logic [INDEX_W-1:0]        index     = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] data;
  logic [POS_W-1:0]          position;
  logic [FILL_W-1:0]         fill;
  logic [STATUS_W-1:0]       status;

  int commands_taken;
  int results_taken;
  int mismatches;

  // Handshake pressure knobs. rx_stall is read by the receiver process, so it only
  // ever changes through a nonblocking write; tx_idle belongs to the sender alone.
  int tx_idle   = 0;
  int rx_stall  = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int sent        = 0;
  int per_op [4]  = '{0, 0, 0, 0};

  sorted_table_binary_insert_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .index     (index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (data),
    .position  (position),
    .fill      (fill),
    .status    (status)
  );

  stbi_table_monitor checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .value          (value),
    .index          (index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data           (data),
    .position       (position),
    .fill           (fill),
    .status         (status),
    .commands_taken (commands_taken),
    .results_taken  (results_taken),
    .mismatches     (mismatches)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: bail out if the run hangs somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands taken, %0d results seen",
               cycle_count, commands_taken, results_taken);
      $display("** sorted_table_binary_insert_top: FAILED **");
      $finish;
    end
  end

  // Receiver. A bump of hold_reqs starts a long hold-off, counted here; otherwise
  // stall at random according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall);
    end
  end

  // Offer one command beat after a random gap and hold it until it is taken.
  task automatic send_cmd(input cmd_t op, input logic signed [VALUE_W-1:0] v,
                          input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= op;
    value    <= v;
    index    <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    per_op[int'(op)]++;
  endtask

  // Drop valid and wait until every result beat owed has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (commands_taken != results_taken) @(posedge clk);
  endtask

  // Advance an ascending run of keys, pinned at the top of the signed range.
  function automatic longint next_sorted(input longint cur, input int unsigned span);
    longint nxt;
    nxt = cur + longint'($urandom_range(span));
    return (nxt > 64'sd2147483647) ? 64'sd2147483647 : nxt;
  endfunction

  // Insert keys: mostly anywhere, often close to the current run so that equal keys
  // and neighbours turn up, now and then the extremes or values around zero.
  function automatic logic signed [VALUE_W-1:0] pick_value(input longint anchor);
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom);
      4, 5, 6:    return anchor[VALUE_W-1:0] + 32'($urandom_range(8)) - 32'd4;
      7:          return 32'sh8000_0000;
      8:          return 32'sh7fff_ffff;
      default:    return 32'($urandom_range(3)) - 32'd2;
    endcase
  endfunction

  // One random stretch. Mostly a well-formed session: clear, an ascending run of loads,
  // then a mix of inserts, reads and further loads that often runs the table full.
  // The rest is noise: any command with any fields.
  task automatic run_sequence();
    longint      cur;
    int unsigned span;
    int          pick;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8))
        send_cmd(cmd_t'($urandom_range(3)), 32'($urandom), 4'($urandom));
      return;
    end
    span = ($urandom_range(1) == 0) ? 32'd3 : 32'h00ff_ffff;
    cur  = longint'($signed($urandom));
    if ($urandom_range(3) == 0) cur = -64'sd2147483648 + 64'($urandom_range(3));
    send_cmd(CMD_CLEAR, 32'($urandom), 4'($urandom));
    repeat ($urandom_range(0, 6)) begin
      cur = next_sorted(cur, span);
      send_cmd(CMD_LOAD, cur[VALUE_W-1:0], 4'($urandom));
    end
    repeat ($urandom_range(4, 24)) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_cmd(CMD_INSERT, pick_value(cur), 4'($urandom));
      end else if (pick < 82) begin
        send_cmd(CMD_READ, 32'($urandom), 4'($urandom));
      end else if (pick < 94) begin
        cur = next_sorted(cur, span);
        send_cmd(CMD_LOAD, cur[VALUE_W-1:0], 4'($urandom));
      end else if (pick < 97) begin
        // out-of-order load: the table loses its order but stays defined
        send_cmd(CMD_LOAD, 32'($urandom), 4'($urandom));
      end else begin
        send_cmd(CMD_CLEAR, 32'($urandom), 4'($urandom));
      end
    end
  endtask

  initial begin
    logic signed [VALUE_W-1:0] fillers [7];
    int idle_pct  [4];
    int stall_pct [4];
    fillers   = '{32'sd100, -32'sd100, 32'sd3, 32'sd3, 32'sh4000_0000, -32'sh4000_0000,
                  -32'sd1};
    // phases: no idling, sender idle, receiver stalling, both a little
    idle_pct  = '{0, 87, 0, 22};
    stall_pct = '{0, 0, 87, 22};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty table, extremes, equal keys, a full table and clears.
    send_cmd(CMD_CLEAR, 32'sd0, 4'd0);             // clear when already empty
    send_cmd(CMD_READ, 32'sd0, 4'd15);             // read on an empty table: range error
    send_cmd(CMD_INSERT, 32'sd0, 4'd0);            // insert into an empty table
    send_cmd(CMD_CLEAR, 32'sd0, 4'd0);             // clear a non-empty table
    send_cmd(CMD_LOAD, 32'sh8000_0000, 4'd0);
    send_cmd(CMD_LOAD, -32'sd5, 4'd0);
    send_cmd(CMD_LOAD, 32'sd7, 4'd0);
    send_cmd(CMD_LOAD, 32'sh7fff_ffff, 4'd0);
    send_cmd(CMD_INSERT, 32'sd7, 4'd0);            // equal key goes after its twin
    send_cmd(CMD_INSERT, 32'sh8000_0000, 4'd0);    // equal to the smallest entry
    send_cmd(CMD_INSERT, 32'sh7fff_ffff, 4'd0);    // equal to the largest entry
    send_cmd(CMD_INSERT, -32'sd6, 4'd0);
    send_cmd(CMD_INSERT, 32'sd0, 4'd0);
    send_cmd(CMD_READ, 32'sd0, 4'd8);              // last filled entry
    send_cmd(CMD_READ, 32'sd0, 4'd9);              // first entry beyond the fill
    foreach (fillers[i]) send_cmd(CMD_INSERT, fillers[i], 4'd0);
    send_cmd(CMD_INSERT, 32'sd5, 4'd0);            // table full: refused
    send_cmd(CMD_LOAD, 32'sd5, 4'd0);              // table full: refused
    send_cmd(CMD_READ, 32'sd0, 4'd15);             // top entry of a full table
    send_cmd(CMD_CLEAR, 32'sd0, 4'd0);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle  = idle_pct[ph];
      rx_stall <= stall_pct[ph];
      if (ph == 0) begin
        // Long output hold-off while commands keep coming: the block backs up and
        // stalls its input. Then pause the sender until every result is home.
        hold_reqs <= hold_reqs + 1;
        send_cmd(CMD_CLEAR, 32'sd0, 4'd0);
        repeat (11) send_cmd(CMD_INSERT, 32'($urandom), 4'($urandom));
        wait_drain();
      end
      while (sent < (ph + 1) * ITEMS / 4) run_sequence();
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d load, %0d insert, %0d read, %0d clear), %0d results",
             sent, per_op[CMD_LOAD], per_op[CMD_INSERT], per_op[CMD_READ], per_op[CMD_CLEAR],
             results_taken);
    $display("checked over four handshake phases and a %0d-cycle output hold; %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("** sorted_table_binary_insert_top: PASSED **");
    end else begin
      $display("** sorted_table_binary_insert_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/stbi_pkg.sv
rtl/core/stbi_cell.sv
rtl/core/stbi_ctrl.sv
rtl/core/sorted_table_binary_insert_top.sv
test/stbi_table_monitor.sv
test/tb.sv
